>>> hw/rtl/json_composite_skipper_macros.svh
// assertion macros for the json composite skipper
// used by the top level only, needs no other file
`ifndef JSON_COMPOSITE_SKIPPER_MACROS_SVH
`define JSON_COMPOSITE_SKIPPER_MACROS_SVH

// expression holds at every clock edge out of reset
`define JCS_ASSERT_HOLDS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define JCS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/jcs_pkg.sv
// shared types and constants of the json composite skipper
// no dependencies
package jcs_pkg;

    localparam int BYTE_W     = 8;
    localparam int DEPTH_W    = 8;
    localparam int STATUS_W   = 3;
    localparam int LENGTH_W   = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int CLS_W      = 3;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 8'd64;
    localparam logic [BYTE_W-1:0]  CTRL_LIMIT      = 8'h20;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_DEEP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CONTROL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_END_STRING = 3'd4;
    localparam logic [STATUS_W-1:0] ST_END_OPEN   = 3'd5;

    // byte classes
    localparam logic [CLS_W-1:0] CLS_OTHER  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_QUOTE  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_BSLASH = 3'd2;
    localparam logic [CLS_W-1:0] CLS_OPEN   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_CLOSE  = 3'd4;
    localparam logic [CLS_W-1:0] CLS_CTRL   = 3'd5;

    // classified byte as it travels through the queue
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             last;
    } jcs_item_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } jcs_q_status_t;

endpackage

>>> hw/rtl/jcs_front.sv
// front end: accepts input bytes and classifies them
// depends on jcs_pkg
module jcs_front import jcs_pkg::*; (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // data_byte
    input  logic                 s_tlast,    // last_byte
    input  jcs_q_status_t        q_stat,
    output logic                 push,
    output jcs_item_t            item
);

    logic [BYTE_W-1:0] b;
    logic [CLS_W-1:0]  cls;

    assign b = s_tdata[BYTE_W-1:0];

    always_comb begin
        if (b == 8'h22) begin
            cls = CLS_QUOTE;
        end else if (b == 8'h5C) begin
            cls = CLS_BSLASH;
        end else if (b == 8'h5B || b == 8'h7B) begin
            cls = CLS_OPEN;
        end else if (b == 8'h5D || b == 8'h7D) begin
            cls = CLS_CLOSE;
        end else if (b < CTRL_LIMIT && b != 8'h09 && b != 8'h0A && b != 8'h0D) begin
            cls = CLS_CTRL;
        end else begin
            cls = CLS_OTHER;
        end
    end

    assign s_tready  = !q_stat.full;
    assign push      = s_tvalid && !q_stat.full;
    assign item.cls  = cls;
    assign item.last = s_tlast;

endmodule

>>> hw/rtl/jcs_fifo.sv
// short queue of classified bytes between front and back
// depends on jcs_pkg
module jcs_fifo import jcs_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jcs_item_t     wr_item,
    input  logic          pop,
    output jcs_item_t     rd_item,
    output jcs_q_status_t q_stat
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

    jcs_item_t        mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item      = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CNT_FULL);
    assign q_stat.empty = (cnt_reg == '0);

endmodule

>>> hw/rtl/jcs_tracker.sv
// back end: depth, string and escape tracking, byte count and result register
// depends on jcs_pkg
module jcs_tracker import jcs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  jcs_item_t            rd_item,
    input  jcs_q_status_t        q_stat,
    output logic                 pop,
    input  logic [DEPTH_W-1:0]   max_depth,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata     // status[2:0], length[34:3], zero pad
);

    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                in_str_reg, in_str_next;
    logic                esc_reg, esc_next;
    logic [LENGTH_W-1:0] count_reg, count_inc;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [LENGTH_W-1:0] out_len_reg;

    logic                done;
    logic [STATUS_W-1:0] status;
    logic [DEPTH_W:0]    depth_up;

    assign pop       = !q_stat.empty && (!out_valid_reg || m_tready);
    assign count_inc = (count_reg == {LENGTH_W{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign depth_up  = {1'b0, depth_reg} + 1'b1;

    always_comb begin
        depth_next  = depth_reg;
        in_str_next = in_str_reg;
        esc_next    = esc_reg;
        done        = 1'b0;
        status      = ST_OK;
        if (in_str_reg) begin
            if (esc_reg) begin
                esc_next = 1'b0;
            end else if (rd_item.cls == CLS_BSLASH) begin
                esc_next = 1'b1;
            end else if (rd_item.cls == CLS_QUOTE) begin
                in_str_next = 1'b0;
            end
        end else begin
            case (rd_item.cls)
                CLS_QUOTE: begin
                    in_str_next = 1'b1;
                end
                CLS_OPEN: begin
                    if (depth_up > {1'b0, max_depth}) begin
                        done   = 1'b1;
                        status = ST_TOO_DEEP;
                    end else begin
                        depth_next = depth_up[DEPTH_W-1:0];
                    end
                end
                CLS_CLOSE: begin
                    if (depth_reg == '0) begin
                        done   = 1'b1;
                        status = ST_UNMATCHED;
                    end else begin
                        depth_next = depth_reg - 1'b1;
                        if (depth_reg == DEPTH_W'(1)) begin
                            done   = 1'b1;
                            status = ST_OK;
                        end
                    end
                end
                CLS_CTRL: begin
                    done   = 1'b1;
                    status = ST_CONTROL;
                end
                default: begin
                end
            endcase
        end
        if (!done && rd_item.last) begin
            done   = 1'b1;
            status = in_str_next ? ST_END_STRING : ST_END_OPEN;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop && done) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            in_str_reg    <= 1'b0;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                if (done) begin
                    depth_reg  <= '0;
                    in_str_reg <= 1'b0;
                    esc_reg    <= 1'b0;
                    count_reg  <= '0;
                end else begin
                    depth_reg  <= depth_next;
                    in_str_reg <= in_str_next;
                    esc_reg    <= esc_next;
                    count_reg  <= count_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && done) begin
            out_status_reg <= status;
            out_len_reg    <= count_inc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W - LENGTH_W){1'b0}}, out_len_reg, out_status_reg};

endmodule

>>> hw/rtl/json_composite_skipper.sv
// top level of the json composite skipper: front, queue, tracker, config register
// depends on jcs_pkg, jcs_front, jcs_fifo, jcs_tracker and the assertion macro header

// Finds where a JSON array or object ends in a byte stream, one byte per
// request on the s_ side. The first byte of a run is normally '[' or '{'.
// A result on the m_ side carries a status (0 closed ok, 1 too deep,
// 2 unmatched close, 3 control byte outside a string, 4 input ended inside a
// string, 5 input ended with brackets open) and the run length, counted from
// the run's first byte through the byte that gave the result, saturating at
// 2^32-1. A new run starts with the byte after any result. Strings are
// tracked so that brackets and quotes inside them, and the byte after a
// backslash, do not count. Throughput is one byte per clock sustained while
// each result is taken on m_tready; a byte that gives a result is written
// into the queue when its request is taken, and its result goes into the
// result register, which drives m_tvalid, when the tracker pops that byte.
// The rate is set by the tracker, which updates depth, string and escape
// flags and the byte count for each byte that it pops. The queue of
// QUEUE_DEPTH classified bytes lets input keep flowing while a result waits
// on m_tready. max_depth is written through the cfg_ port (always ready) and
// resets to 64; a value of zero makes every opener give status 1.
`include "json_composite_skipper_macros.svh"

module json_composite_skipper import jcs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [DEPTH_W-1:0]   cfg_data,   // max_depth
    // byte input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // data_byte[7:0]
    input  logic                 s_tlast,    // last_byte
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata     // status[2:0], length[34:3], zero [39:35]
);

    logic [DEPTH_W-1:0] max_depth_reg;
    jcs_q_status_t      q_stat;
    jcs_item_t          wr_item;
    jcs_item_t          rd_item;
    logic               q_push;
    logic               q_pop;
    logic               m_fields_ok;

    // max_depth register, writes may land at any time the block is idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_depth_reg <= MAX_DEPTH_RESET;
        end else if (cfg_valid) begin
            max_depth_reg <= cfg_data;
        end
    end

    // front: take the request, classify the byte, push into the queue
    jcs_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (q_push),
        .item     (wr_item)
    );

    // queue between classification and tracking
    jcs_fifo #(
        .QDEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_item (wr_item),
        .pop     (q_pop),
        .rd_item (rd_item),
        .q_stat  (q_stat)
    );

    // back: run state and the result register
    jcs_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_item   (rd_item),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .max_depth (max_depth_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // status code in range and pad bits clear
    assign m_fields_ok = (m_tdata[2:0] <= ST_END_OPEN) && (m_tdata[39:35] == 5'd0);

    // result fields sane whenever a result is shown
    `JCS_ASSERT_IMPLIES(a_status_range, aclk, aresetn, m_tvalid, m_fields_ok, "bad result")

    // queue can never look full and empty at once
    `JCS_ASSERT_HOLDS(a_queue_sane, aclk, aresetn, !(q_stat.full && q_stat.empty), "queue state")

    // the tracker must not consume a byte while a result is held back
    `JCS_ASSERT_IMPLIES(a_stall_pop, aclk, aresetn, m_tvalid && !m_tready, !q_pop, "pop on stall")

endmodule
